### src/stack_machine_executor_top_macros.svh
// Assertion macros for the stack machine executor checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH

// same-cycle implication, muted during reset
`define SMV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define SMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/smv_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; most design files refer to it by scoped names, the test files import it.
`timescale 1ns / 1ps

package smv_pkg;

  localparam int KIND_W  = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 9;

  localparam logic [KIND_W-1:0] OP_HALT = 8'd0;
  localparam logic [KIND_W-1:0] OP_PUSH = 8'd1;
  localparam logic [KIND_W-1:0] OP_POP  = 8'd2;
  localparam logic [KIND_W-1:0] OP_ADD  = 8'd3;
  localparam logic [KIND_W-1:0] OP_MUL  = 8'd4;
  localparam logic [KIND_W-1:0] OP_DIV  = 8'd5;
  localparam logic [KIND_W-1:0] OP_SUB  = 8'd6;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4,
    ST_DIVZERO = 3'd5,
    ST_IGNORED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB
  } state_t;

endpackage

### src/smv_if.sv
// Channel interfaces for the stack machine executor: instruction in, result out.
// Depends on smv_pkg for field widths.
`timescale 1ns / 1ps

interface smv_in_if;
  logic                               valid;
  logic                               ready;
  logic [smv_pkg::KIND_W-1:0]         kind;
  logic signed [smv_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

interface smv_out_if;
  logic                               valid;
  logic                               ready;
  logic [smv_pkg::STAT_W-1:0]         status;
  logic signed [smv_pkg::DATA_W-1:0]  top_value;
  logic [smv_pkg::DEPTH_W-1:0]        depth;
  logic signed [smv_pkg::DATA_W-1:0]  left_operand;
  logic signed [smv_pkg::DATA_W-1:0]  right_operand;
  logic signed [smv_pkg::DATA_W-1:0]  op_result;

  modport source (output valid, status, top_value, depth, left_operand, right_operand,
                  op_result, input ready);
  modport sink   (input valid, status, top_value, depth, left_operand, right_operand,
                  op_result, output ready);
endinterface

### src/smv_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module smv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/smv_div.sv
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on smv_pkg for the data width. Divisor must be nonzero.
`timescale 1ns / 1ps

module smv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smv_pkg::DATA_W-1:0]  dividend,
  input  logic [smv_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [smv_pkg::DATA_W-1:0]  quotient
);

  localparam int W  = smv_pkg::DATA_W;
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  mb_r, mb_nxt;
  logic          neg_r, neg_nxt;

  logic [W:0]    rem_sh;
  logic          ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    rem_sh   = {rem_r[W-1:0], quo_r[W-1]};
    ge       = (rem_sh >= {1'b0, mb_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mb_nxt   = mb_r;
    neg_nxt  = neg_r;
    if (start) begin
      // work on magnitudes, fix the sign at the end
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? (W'(0) - dividend) : dividend;
      mb_nxt   = divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, mb_r}) : rem_sh;
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

### src/stack_machine_executor_top.sv
// Stack machine executor: one instruction per input beat, one result beat per
// instruction. Stack entries live in a synchronous RAM of STACK_DEPTH words;
// the top entry is mirrored in a register so each instruction needs at most one
// RAM read (the second entry) and one write. Push, pop, halt, unknown opcodes
// and all faults are accepted, then executed; add, sub and mul are read, then
// computed into a register and written back, and div also waits on the 32-step
// one-bit-per-cycle divider. Faults leave the stack untouched; after a halt
// every later instruction reports ignored until reset. The next instruction is
// taken while the previous result is still waiting at the output register.
// Depends on smv_pkg, smv_if, smv_ram and smv_div.
`timescale 1ns / 1ps

module stack_machine_executor_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  smv_in_if.sink    in_ch,
  smv_out_if.source out_ch
);

  localparam int W  = smv_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int OW = smv_pkg::DEPTH_W;

  smv_pkg::state_t  state_r, state_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic             halted_r, halted_nxt;
  logic [W-1:0]     top_r, top_nxt;

  logic [smv_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [W-1:0]     pv_r, pv_nxt;
  logic [W-1:0]     left_r, left_nxt;
  logic [W-1:0]     right_r, right_nxt;
  logic [W-1:0]     res_r, res_nxt;

  logic             out_valid_r, out_valid_nxt;
  smv_pkg::status_t o_status_r, o_status_nxt;
  logic [W-1:0]     o_top_r, o_top_nxt;
  logic [OW-1:0]    o_depth_r, o_depth_nxt;
  logic [W-1:0]     o_left_r, o_left_nxt;
  logic [W-1:0]     o_right_r, o_right_nxt;
  logic [W-1:0]     o_res_r, o_res_nxt;

  logic             in_ready;
  logic             slot_free;
  logic             load_out;
  logic             arith_op;
  logic             arith_go;
  logic [DW-1:0]    depth_m2;
  logic [AW-1:0]    sec_addr;
  logic [DW+OW-1:0] depth_ext;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata, ram_rdata;

  logic             div_start, div_done;
  logic [W-1:0]     div_q;

  smv_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (sec_addr),
    .rdata (ram_rdata)
  );

  smv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign depth_m2  = depth_r - DW'(2);
  assign sec_addr  = depth_m2[AW-1:0];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign arith_op  = (kind_r == smv_pkg::OP_ADD) || (kind_r == smv_pkg::OP_MUL) ||
                     (kind_r == smv_pkg::OP_DIV) || (kind_r == smv_pkg::OP_SUB);
  assign arith_go  = !halted_r && arith_op && (depth_r >= DW'(2)) &&
                     !((kind_r == smv_pkg::OP_DIV) && (top_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smv_pkg::S_IDLE;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    kind_r     <= kind_nxt;
    pv_r       <= pv_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    res_r      <= res_nxt;
    o_status_r <= o_status_nxt;
    o_top_r    <= o_top_nxt;
    o_depth_r  <= o_depth_nxt;
    o_left_r   <= o_left_nxt;
    o_right_r  <= o_right_nxt;
    o_res_r    <= o_res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    halted_nxt   = halted_r;
    top_nxt      = top_r;
    kind_nxt     = kind_r;
    pv_nxt       = pv_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = depth_r[AW-1:0];
    ram_wdata    = pv_r;
    div_start    = 1'b0;
    o_status_nxt = o_status_r;
    o_left_nxt   = '0;
    o_right_nxt  = '0;
    o_res_nxt    = '0;

    unique case (state_r)
      smv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          pv_nxt    = in_ch.push_value;
          ram_re    = 1'b1;   // second entry, ready in S_EXEC
          state_nxt = smv_pkg::S_EXEC;
        end
      end

      smv_pkg::S_EXEC: begin
        if (arith_go) begin
          left_nxt  = ram_rdata;
          right_nxt = top_r;
          state_nxt = smv_pkg::S_WB;
          case (kind_r)
            smv_pkg::OP_ADD: res_nxt = ram_rdata + top_r;
            smv_pkg::OP_SUB: res_nxt = ram_rdata - top_r;
            smv_pkg::OP_MUL: res_nxt = ram_rdata * top_r;
            default: begin
              div_start = 1'b1;
              state_nxt = smv_pkg::S_DIV;
            end
          endcase
        end else if (slot_free) begin
          load_out     = 1'b1;
          state_nxt    = smv_pkg::S_IDLE;
          o_status_nxt = smv_pkg::ST_OK;
          if (halted_r) begin
            o_status_nxt = smv_pkg::ST_IGNORED;
          end else begin
            unique case (kind_r) inside
              smv_pkg::OP_HALT: begin
                halted_nxt   = 1'b1;
                o_status_nxt = smv_pkg::ST_HALT;
              end
              smv_pkg::OP_PUSH: begin
                if (depth_r >= DW'(STACK_DEPTH)) begin
                  o_status_nxt = smv_pkg::ST_OVER;
                end else begin
                  ram_we    = 1'b1;
                  top_nxt   = pv_r;
                  depth_nxt = depth_r + DW'(1);
                end
              end
              smv_pkg::OP_POP: begin
                if (depth_r == '0) begin
                  o_status_nxt = smv_pkg::ST_UNDER;
                end else begin
                  top_nxt   = ram_rdata;
                  depth_nxt = depth_r - DW'(1);
                end
              end
              smv_pkg::OP_ADD, smv_pkg::OP_MUL, smv_pkg::OP_DIV, smv_pkg::OP_SUB: begin
                // only faults reach here
                if (depth_r < DW'(2)) begin
                  o_status_nxt = smv_pkg::ST_UNDER;
                end else begin
                  o_status_nxt = smv_pkg::ST_DIVZERO;
                  o_left_nxt   = ram_rdata;
                  o_right_nxt  = top_r;
                end
              end
              default: begin
                o_status_nxt = smv_pkg::ST_UNKNOWN;
              end
            endcase
          end
        end
      end

      smv_pkg::S_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = smv_pkg::S_WB;
        end
      end

      smv_pkg::S_WB: begin
        if (slot_free) begin
          ram_we       = 1'b1;
          ram_waddr    = sec_addr;
          ram_wdata    = res_r;
          top_nxt      = res_r;
          depth_nxt    = depth_r - DW'(1);
          load_out     = 1'b1;
          o_status_nxt = smv_pkg::ST_OK;
          o_left_nxt   = left_r;
          o_right_nxt  = right_r;
          o_res_nxt    = res_r;
          state_nxt    = smv_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = smv_pkg::S_IDLE;
      end
    endcase

    if (!load_out) begin
      o_left_nxt  = o_left_r;
      o_right_nxt = o_right_r;
      o_res_nxt   = o_res_r;
    end
  end

  // result view of the stack after this instruction
  assign depth_ext     = {{OW{1'b0}}, depth_nxt};
  assign o_depth_nxt   = load_out ? depth_ext[OW-1:0] : o_depth_r;
  assign o_top_nxt     = !load_out ? o_top_r : ((depth_nxt == '0) ? '0 : top_nxt);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.top_value     = o_top_r;
  assign out_ch.depth         = o_depth_r;
  assign out_ch.left_operand  = o_left_r;
  assign out_ch.right_operand = o_right_r;
  assign out_ch.op_result     = o_res_r;

endmodule

### src/smv_checker.sv
// Port-level checker for the stack machine executor, bound to the top level.
// Depends on smv_pkg and stack_machine_executor_top_macros.svh.
`timescale 1ns / 1ps
`include "stack_machine_executor_top_macros.svh"

module smv_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [smv_pkg::STAT_W-1:0]  out_status,
  input logic [smv_pkg::DATA_W-1:0]  out_top_value,
  input logic [smv_pkg::DEPTH_W-1:0] out_depth
);

  logic                        in_beat, out_beat;
  logic                        seen_halt_r;
  logic [smv_pkg::DEPTH_W-1:0] prev_depth_r;
  logic [1:0]                  pending_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r  <= 1'b0;
      prev_depth_r <= '0;
      pending_r    <= '0;
    end else begin
      if (out_beat && (out_status == smv_pkg::ST_HALT)) begin
        seen_halt_r <= 1'b1;
      end
      if (out_beat) begin
        prev_depth_r <= out_depth;
      end
      pending_r <= pending_r + 2'(in_beat) - 2'(out_beat);
    end
  end

  `SMV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_top_value) && $stable(out_depth),
    "result beat changed while stalled")

  `SMV_ASSERT_IMPL(a_after_halt, out_beat && seen_halt_r,
    out_status == smv_pkg::ST_IGNORED, "instruction executed after halt")

  `SMV_ASSERT_IMPL(a_fault_depth, out_beat && (out_status != smv_pkg::ST_OK),
    out_depth == prev_depth_r, "stack depth moved on a non-ok result")

  `SMV_ASSERT_IMPL(a_in_flight, 1'b1, pending_r != 2'd3,
    "in/out beat count out of range")

endmodule

bind stack_machine_executor_top smv_port_checker u_smv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_top_value (out_ch.top_value),
  .out_depth     (out_ch.depth)
);

### test/smv_checker.sv
// Scoreboard for the stack machine executor: tracks the stack for every accepted
// instruction beat and checks each result beat in order. Depends on smv_pkg and smv_if.
`timescale 1ns / 1ps

module smv_checker #(
  parameter int STACK_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  smv_in_if    in_mon,
  smv_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import smv_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;
    logic [DATA_W-1:0]   left_operand;
    logic [DATA_W-1:0]   right_operand;
    logic [DATA_W-1:0]   op_result;
  } exec_result_t;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       sp = 0;
  logic              halted = 1'b0;
  exec_result_t      result_q[$];
  int                mismatches = 0;

  // signed divide, truncating toward zero; MIN / -1 wraps back to MIN
  function automatic logic [DATA_W-1:0] quot_trunc(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[DATA_W-1] ? (32'd0 - a) : a;
    mb = b[DATA_W-1] ? (32'd0 - b) : b;
    q  = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - q) : q;
  endfunction

  function automatic exec_result_t exec_instr(input logic [KIND_W-1:0] op,
                                              input logic [DATA_W-1:0] imm);
    exec_result_t r;
    logic [DATA_W-1:0] lhs, rhs, res;
    r   = '0;
    lhs = '0;
    rhs = '0;
    res = '0;
    r.status = ST_OK;
    if (halted) begin
      r.status = ST_IGNORED;
    end else begin
      case (op)
        OP_HALT: begin
          halted   = 1'b1;
          r.status = ST_HALT;
        end
        OP_PUSH: begin
          if (sp >= STACK_DEPTH) begin
            r.status = ST_OVER;
          end else begin
            stack_mem[sp] = imm;
            sp++;
          end
        end
        OP_POP: begin
          if (sp == 0) r.status = ST_UNDER;
          else sp--;
        end
        OP_ADD, OP_MUL, OP_DIV, OP_SUB: begin
          if (sp < 2) begin
            r.status = ST_UNDER;
          end else begin
            rhs = stack_mem[sp-1];
            lhs = stack_mem[sp-2];
            if (op == OP_DIV && rhs == '0) begin
              // operands still reported, nothing written back
              r.status = ST_DIVZERO;
            end else begin
              case (op)
                OP_ADD:  res = lhs + rhs;
                OP_MUL:  res = lhs * rhs;
                OP_DIV:  res = quot_trunc(lhs, rhs);
                default: res = lhs - rhs;
              endcase
              stack_mem[sp-2] = res;
              sp--;
            end
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
    end
    r.left_operand  = lhs;
    r.right_operand = rhs;
    r.op_result     = res;
    r.top_value     = (sp > 0) ? stack_mem[sp-1] : '0;
    r.depth         = DEPTH_W'(sp);
    return r;
  endfunction

  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst_n) begin
      sp     = 0;
      halted = 1'b0;
      result_q.delete();
    end else begin
      // result side first: a result beat always belongs to an earlier instruction
      if (out_mon.valid && out_mon.ready) begin
        got.status        = status_t'(out_mon.status);
        got.top_value     = out_mon.top_value;
        got.depth         = out_mon.depth;
        got.left_operand  = out_mon.left_operand;
        got.right_operand = out_mon.right_operand;
        got.op_result     = out_mon.op_result;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: st=%0d top=%h depth=%0d l=%h r=%h res=%h",
                     $realtime, got.status, got.top_value, got.depth, got.left_operand,
                     got.right_operand, got.op_result);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result beat differs", $realtime);
              $display("  got : st=%0d top=%h depth=%0d l=%h r=%h res=%h", got.status,
                       got.top_value, got.depth, got.left_operand, got.right_operand,
                       got.op_result);
              $display("  want: st=%0d top=%h depth=%0d l=%h r=%h res=%h", want.status,
                       want.top_value, want.depth, want.left_operand, want.right_operand,
                       want.op_result);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(exec_instr(in_mon.kind, in_mon.push_value));
    end
    fail_count <= mismatches;
    pending    <= result_q.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for the stack machine executor: clock, reset, instruction
// stimulus, result-side backpressure and the verdict. Depends on smv_pkg,
// smv_if, smv_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import smv_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [KIND_W-1:0] OP_FIRST_UNKNOWN = OP_SUB + 1'b1;
  localparam logic [KIND_W-1:0] OP_LAST_UNKNOWN  = '1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   depth_est = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;

  logic [KIND_W-1:0] arith_ops [4] = '{OP_ADD, OP_MUL, OP_DIV, OP_SUB};

  smv_in_if  in_ch();
  smv_out_if out_ch();

  stack_machine_executor_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  smv_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // small values, so zero divisors and exact quotients show up
        v = $urandom_range(0, 16);
        return v - 32'd8;
      end
      3: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] imm);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.push_value <= imm;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_PUSH: if (depth_est < STACK_DEPTH) depth_est++;
      OP_POP:  if (depth_est > 0) depth_est--;
      OP_ADD, OP_MUL, OP_DIV, OP_SUB: if (depth_est >= 2) depth_est--;
      default: ;
    endcase
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // mostly well-formed push/arith traffic, some pops and unknown opcodes
  task automatic random_instr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)
      issue(KIND_W'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN)), $urandom);
    else if (r < 12)
      issue(OP_POP, $urandom);
    else if ((r < 56 || depth_est < 2) && depth_est < 200)
      issue(OP_PUSH, pick_value());
    else
      issue(arith_ops[$urandom_range(0, 3)], $urandom);
  endtask

  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= OP_PUSH;
    in_ch.push_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    issue(OP_POP, $urandom);             // pop on empty
    issue(OP_ADD, $urandom);             // arith on empty
    issue(OP_PUSH, 32'h7fff_ffff);
    issue(OP_SUB, $urandom);             // arith with one entry
    issue(OP_PUSH, 32'h0000_0001);
    issue(OP_ADD, $urandom);             // wraps to most negative
    issue(OP_PUSH, 32'hffff_ffff);
    issue(OP_DIV, $urandom);             // most negative / -1
    issue(OP_PUSH, 32'h0000_0000);
    issue(OP_DIV, $urandom);             // divide by zero
    issue(OP_POP, $urandom);
    issue(OP_PUSH, 32'h0000_0003);
    issue(OP_MUL, $urandom);
    issue(OP_PUSH, 32'hffff_fff9);
    issue(OP_PUSH, 32'h0000_0002);
    issue(OP_DIV, $urandom);             // -7 / 2 truncates to -3
    issue(OP_PUSH, 32'h0000_0005);
    issue(OP_PUSH, 32'h0000_0009);
    issue(OP_SUB, $urandom);
    issue(OP_FIRST_UNKNOWN, $urandom);
    issue(OP_LAST_UNKNOWN, $urandom);
    issue(OP_PUSH, 32'h8000_0000);

    for (int i = 0; i < 600; i++) begin
      if (i == 200) hold_req = 1'b1;     // output held off while input keeps coming
      random_instr();
    end

    // fill past the top, then work at full depth
    repeat (STACK_DEPTH + 6) issue(OP_PUSH, pick_value());
    repeat (4) issue(arith_ops[$urandom_range(0, 3)], $urandom);

    // empty it past the bottom
    repeat (STACK_DEPTH + 6) issue(OP_POP, $urandom);
    issue(OP_MUL, $urandom);
    drain_pause();

    for (int i = 0; i < 700; i++) begin
      if (i == 500) quiet = 1'b1;
      random_instr();
    end

    // halt, then everything after it is ignored
    issue(OP_HALT, $urandom);
    issue(OP_PUSH, pick_value());
    issue(OP_HALT, $urandom);
    issue(OP_ADD, $urandom);
    issue(OP_LAST_UNKNOWN, $urandom);

    drain_pause();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/smv_pkg.sv
src/smv_if.sv
src/smv_ram.sv
src/smv_div.sv
src/stack_machine_executor_top.sv
src/smv_checker.sv
test/smv_checker.sv
test/tb_top.sv
